FILE: hdl/idle_cpu_placement_selector_defines.svh
// Assertion macros used by the selector RTL.
// Each macro expects clk and rst to be visible in the module that uses it.
`ifndef IDLE_CPU_PLACEMENT_SELECTOR_DEFINES_SVH
`define IDLE_CPU_PLACEMENT_SELECTOR_DEFINES_SVH

// Same-cycle implication
`define ICPS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ICPS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/icps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package icps_pkg;

  // Fixed field widths
  localparam int CPU_ID_W    = 3;
  localparam int REASON_W    = 2;
  localparam int OUT_TDATA_W = 8;
  // Wide enough to compare a CPU index against any supported CPU count
  localparam int CPU_CMP_W   = 7;

  // choice_reason codes
  localparam logic [REASON_W-1:0] REASON_PREV = 2'd0;
  localparam logic [REASON_W-1:0] REASON_IDLE = 2'd1;
  localparam logic [REASON_W-1:0] REASON_BUSY = 2'd2;
  localparam logic [REASON_W-1:0] REASON_NA   = 2'd3;

endpackage

`default_nettype wire

FILE: hdl/idle_cpu_placement_selector.sv
`timescale 1ns / 1ps
`default_nettype none

// Idle-CPU placement selector. Feed one request per CPU, in cluster order,
// with s_tlast on the final CPU of the placement; one result (target CPU and
// reason) comes out per placement, in the cycle after the last request is
// taken. Each request is handled combinationally: one add and the compares
// against the running bests sit between the request and the state/result
// registers, so requests may arrive back to back. The only stall comes from
// the single result register: s_tready drops while a result waits and
// m_tready is low. State clears itself after every last request.
module idle_cpu_placement_selector
  import icps_pkg::*;
#(
  parameter int CPU_COUNT = 8,
  parameter int UTIL_BITS = 11,
  localparam int IN_BITS    = CPU_ID_W + 3 + 3 * UTIL_BITS + 1 + CPU_ID_W + 1,
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
  input  wire                    clk,
  input  wire                    rst,
  // Input request channel
  input  wire                    s_tvalid,
  output logic                   s_tready,
  // s_tdata, low bit up: cpu_id, allowed, active, is_idle, cpu_load,
  // task_util, capacity, cluster_end, fallback_cpu, prefer_idle, zero pad
  input  wire [IN_TDATA_W-1:0]   s_tdata,
  input  wire                    s_tlast,   // last_cpu
  // Result channel
  output logic                   m_tvalid,
  input  wire                    m_tready,
  // m_tdata, low bit up: chosen_cpu, choice_reason, zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  `include "idle_cpu_placement_selector_defines.svh"

  localparam int P_ALLOWED = CPU_ID_W;
  localparam int P_ACTIVE  = CPU_ID_W + 1;
  localparam int P_IDLE    = CPU_ID_W + 2;
  localparam int P_WAKE    = CPU_ID_W + 3;
  localparam int P_TASK    = P_WAKE + UTIL_BITS;
  localparam int P_CAP     = P_TASK + UTIL_BITS;
  localparam int P_CEND    = P_CAP + UTIL_BITS;
  localparam int P_PREV    = P_CEND + 1;
  localparam int P_PIDLE   = P_PREV + CPU_ID_W;

  localparam logic [UTIL_BITS-1:0] UTIL_MAX = {UTIL_BITS{1'b1}};

  // Field unpack
  logic [CPU_ID_W-1:0]  cpu_id;
  logic                 allowed, active, is_idle, cluster_end, prefer_idle;
  logic [UTIL_BITS-1:0] cpu_load, task_util, capacity;
  logic [CPU_ID_W-1:0]  fallback_cpu;

  assign cpu_id       = s_tdata[CPU_ID_W-1:0];
  assign allowed      = s_tdata[P_ALLOWED];
  assign active       = s_tdata[P_ACTIVE];
  assign is_idle      = s_tdata[P_IDLE];
  assign cpu_load     = s_tdata[P_WAKE +: UTIL_BITS];
  assign task_util    = s_tdata[P_TASK +: UTIL_BITS];
  assign capacity     = s_tdata[P_CAP +: UTIL_BITS];
  assign cluster_end  = s_tdata[P_CEND];
  assign fallback_cpu = s_tdata[P_PREV +: CPU_ID_W];
  assign prefer_idle  = s_tdata[P_PIDLE];

  // Selection state
  logic [UTIL_BITS-1:0] best_idle_util, best_busy_util, held_capacity;
  logic                 best_idle_valid, best_busy_valid, decided;
  logic [CPU_ID_W-1:0]  best_idle_cpu, best_busy_cpu, decided_cpu;
  logic [REASON_W-1:0]  decided_reason;

  logic [UTIL_BITS-1:0] best_idle_util_next, best_busy_util_next, held_capacity_next;
  logic                 best_idle_valid_next, best_busy_valid_next, decided_next;
  logic [CPU_ID_W-1:0]  best_idle_cpu_next, best_busy_cpu_next, decided_cpu_next;
  logic [REASON_W-1:0]  decided_reason_next;

  // Result register
  logic [CPU_ID_W-1:0]  chosen_cpu, chosen_cpu_next;
  logic [REASON_W-1:0]  choice_reason, choice_reason_next;

  logic                 accept;
  logic                 in_range, eligible, fits, take_idle, take_busy, close_cluster;
  logic [UTIL_BITS:0]   proj;
  logic [UTIL_BITS-1:0] proj_u;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {{(OUT_TDATA_W - CPU_ID_W - REASON_W){1'b0}}, choice_reason, chosen_cpu};

  // Projection and candidate tests
  assign in_range = {{(CPU_CMP_W - CPU_ID_W){1'b0}}, cpu_id} < CPU_CMP_W'(CPU_COUNT);
  assign eligible = !decided && allowed && active && in_range;
  assign proj     = {1'b0, cpu_load} + {1'b0, task_util};
  assign fits     = proj <= {1'b0, capacity};
  assign proj_u   = proj[UTIL_BITS-1:0];
  assign take_idle = eligible && fits && is_idle &&
                     (!best_idle_valid || proj_u < best_idle_util);
  assign take_busy = eligible && fits && !take_idle && capacity <= held_capacity &&
                     (!best_busy_valid || proj_u < best_busy_util);
  assign close_cluster = !decided && (cluster_end || s_tlast);

  // Next state for one request
  always_comb begin
    best_idle_util_next  = best_idle_util;
    best_idle_valid_next = best_idle_valid;
    best_idle_cpu_next   = best_idle_cpu;
    best_busy_util_next  = best_busy_util;
    best_busy_valid_next = best_busy_valid;
    best_busy_cpu_next   = best_busy_cpu;
    held_capacity_next   = held_capacity;
    decided_next         = decided;
    decided_cpu_next     = decided_cpu;
    decided_reason_next  = decided_reason;

    if (take_idle) begin
      best_idle_util_next  = proj_u;
      best_idle_cpu_next   = cpu_id;
      best_idle_valid_next = 1'b1;
    end
    if (take_busy) begin
      best_busy_util_next  = proj_u;
      best_busy_cpu_next   = cpu_id;
      best_busy_valid_next = 1'b1;
      held_capacity_next   = capacity;
    end

    // Idle choice wins over busy choice at a cluster boundary
    if (close_cluster) begin
      if (best_idle_valid_next) begin
        decided_next        = 1'b1;
        decided_cpu_next    = best_idle_cpu_next;
        decided_reason_next = REASON_IDLE;
      end else if (best_busy_valid_next) begin
        decided_next        = 1'b1;
        decided_cpu_next    = best_busy_cpu_next;
        decided_reason_next = REASON_BUSY;
      end
    end

    // Result for the last request
    if (!prefer_idle) begin
      chosen_cpu_next    = '0;
      choice_reason_next = REASON_NA;
    end else if (decided_next) begin
      chosen_cpu_next    = decided_cpu_next;
      choice_reason_next = decided_reason_next;
    end else begin
      chosen_cpu_next    = fallback_cpu;
      choice_reason_next = REASON_PREV;
    end
  end

  // State registers; a last request returns them to reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      best_idle_util  <= UTIL_MAX;
      best_idle_valid <= 1'b0;
      best_idle_cpu   <= '0;
      best_busy_util  <= UTIL_MAX;
      best_busy_valid <= 1'b0;
      best_busy_cpu   <= '0;
      held_capacity   <= UTIL_MAX;
      decided         <= 1'b0;
      decided_cpu     <= '0;
      decided_reason  <= REASON_PREV;
    end else if (accept) begin
      if (s_tlast) begin
        best_idle_util  <= UTIL_MAX;
        best_idle_valid <= 1'b0;
        best_idle_cpu   <= '0;
        best_busy_util  <= UTIL_MAX;
        best_busy_valid <= 1'b0;
        best_busy_cpu   <= '0;
        held_capacity   <= UTIL_MAX;
        decided         <= 1'b0;
        decided_cpu     <= '0;
        decided_reason  <= REASON_PREV;
      end else begin
        best_idle_util  <= best_idle_util_next;
        best_idle_valid <= best_idle_valid_next;
        best_idle_cpu   <= best_idle_cpu_next;
        best_busy_util  <= best_busy_util_next;
        best_busy_valid <= best_busy_valid_next;
        best_busy_cpu   <= best_busy_cpu_next;
        held_capacity   <= held_capacity_next;
        decided         <= decided_next;
        decided_cpu     <= decided_cpu_next;
        decided_reason  <= decided_reason_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      chosen_cpu    <= chosen_cpu_next;
      choice_reason <= choice_reason_next;
    end
  end

  // Checks
  `ICPS_ASSERT_NEXT(a_last_clears, accept && s_tlast, !decided && !best_idle_valid && !best_busy_valid, "state not cleared after last request")
  `ICPS_ASSERT_NEXT(a_last_gives_result, accept && s_tlast, m_tvalid, "no result after last request")
  `ICPS_ASSERT_NOW(a_decided_has_best, decided, best_idle_valid || best_busy_valid, "decision without a candidate")
  `ICPS_ASSERT_NOW(a_idle_reason_valid, decided && decided_reason == REASON_IDLE, best_idle_valid, "idle decision without idle candidate")
  `ICPS_ASSERT_NOW(a_held_cap_idle, !best_busy_valid, held_capacity == UTIL_MAX, "held capacity moved without busy candidate")

endmodule

`default_nettype wire

FILE: tb/idle_cpu_placement_selector_tb.sv
`timescale 1ns / 1ps

module idle_cpu_placement_selector_tb;
  import icps_pkg::*;

  localparam int CPUS       = 8;
  localparam int UTIL_W     = 11;
  localparam int IN_TDATA_W = 48;
  localparam int RAND_ITEMS = 1100;

  // One CPU request as the sender sees it
  typedef struct {
    logic [CPU_ID_W-1:0] cpu_id;
    logic                allowed;
    logic                active;
    logic                is_idle;
    logic [UTIL_W-1:0]   cpu_load;
    logic [UTIL_W-1:0]   task_util;
    logic [UTIL_W-1:0]   capacity;
    logic                cluster_end;
    logic                last_cpu;
    logic [CPU_ID_W-1:0] fallback_cpu;
    logic                prefer_idle;
  } cpu_req_t;

  typedef struct {
    logic [CPU_ID_W-1:0] chosen_cpu;
    logic [REASON_W-1:0] choice_reason;
  } placement_t;

  // Tracks the running bests of the current placement and the placements
  // still owed by the block.
  class placement_scoreboard;
    logic [UTIL_W-1:0]   idle_util, busy_util, held_cap;
    logic                idle_valid, busy_valid, decided;
    logic [CPU_ID_W-1:0] idle_pick, busy_cpu, pick_cpu;
    logic [REASON_W-1:0] pick_reason;
    placement_t          pending_q[$];
    int                  fail_count;

    function new();
      fail_count = 0;
      clear_state();
    endfunction

    function void clear_state();
      idle_util   = '1;
      busy_util   = '1;
      held_cap    = '1;
      idle_valid  = 1'b0;
      busy_valid  = 1'b0;
      decided     = 1'b0;
      idle_pick   = '0;
      busy_cpu    = '0;
      pick_cpu    = '0;
      pick_reason = REASON_PREV;
    endfunction

    function void note_request(cpu_req_t r);
      logic [UTIL_W:0] proj;
      placement_t      p;
      proj = {1'b0, r.cpu_load} + {1'b0, r.task_util};
      // update the running bests
      if (!decided && r.allowed && r.active && int'(r.cpu_id) < CPUS) begin
        if (proj <= {1'b0, r.capacity}) begin
          if (r.is_idle && (!idle_valid || proj < {1'b0, idle_util})) begin
            idle_util  = proj[UTIL_W-1:0];
            idle_pick  = r.cpu_id;
            idle_valid = 1'b1;
          end else if (r.capacity <= held_cap &&
                       (!busy_valid || proj < {1'b0, busy_util})) begin
            busy_util  = proj[UTIL_W-1:0];
            busy_cpu   = r.cpu_id;
            busy_valid = 1'b1;
            held_cap   = r.capacity;
          end
        end
      end
      // cluster boundary: idle choice beats busy choice
      if (!decided && (r.cluster_end || r.last_cpu)) begin
        if (idle_valid) begin
          decided     = 1'b1;
          pick_cpu    = idle_pick;
          pick_reason = REASON_IDLE;
        end else if (busy_valid) begin
          decided     = 1'b1;
          pick_cpu    = busy_cpu;
          pick_reason = REASON_BUSY;
        end
      end
      if (r.last_cpu) begin
        if (!r.prefer_idle) begin
          p.chosen_cpu    = '0;
          p.choice_reason = REASON_NA;
        end else if (decided) begin
          p.chosen_cpu    = pick_cpu;
          p.choice_reason = pick_reason;
        end else begin
          p.chosen_cpu    = r.fallback_cpu;
          p.choice_reason = REASON_PREV;
        end
        pending_q.push_back(p);
        clear_state();
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      placement_t p;
      if (pending_q.size() == 0) begin
        $error("unexpected placement result: m_tdata=%0h", d);
        fail_count++;
        return;
      end
      p = pending_q.pop_front();
      if (d[2:0] !== p.chosen_cpu) begin
        $error("chosen_cpu: expected %0d, got %0d", p.chosen_cpu, d[2:0]);
        fail_count++;
      end
      if (d[4:3] !== p.choice_reason) begin
        $error("choice_reason: expected %0d, got %0d", p.choice_reason, d[4:3]);
        fail_count++;
      end
      if (d[OUT_TDATA_W-1:5] !== '0) begin
        $error("pad: expected 0, got %0h", d[OUT_TDATA_W-1:5]);
        fail_count++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  placement_scoreboard sb = new();
  int  items_sent = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  bit  long_stall_req = 1'b0;

  idle_cpu_placement_selector i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0) return int'($urandom_range(12, 40));
    return int'($urandom_range(1, 3));
  endfunction

  function automatic cpu_req_t mk(int cpu, bit alw, bit act, bit idl, int wake, int tsk,
                                  int cap, bit cend, bit last, int prev, bit pidle);
    cpu_req_t r;
    r.cpu_id       = CPU_ID_W'(cpu);
    r.allowed      = alw;
    r.active       = act;
    r.is_idle      = idl;
    r.cpu_load     = UTIL_W'(wake);
    r.task_util    = UTIL_W'(tsk);
    r.capacity     = UTIL_W'(cap);
    r.cluster_end  = cend;
    r.last_cpu     = last;
    r.fallback_cpu = CPU_ID_W'(prev);
    r.prefer_idle  = pidle;
    return r;
  endfunction

  function automatic cpu_req_t random_req();
    cpu_req_t r;
    r.cpu_id      = CPU_ID_W'($urandom_range(0, CPUS - 1));
    r.allowed     = ($urandom_range(0, 7) != 0);
    r.active      = ($urandom_range(0, 7) != 0);
    r.is_idle     = ($urandom_range(0, 2) == 0);
    r.cpu_load    = UTIL_W'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 2047)
                                                         : $urandom_range(0, 1024));
    r.task_util   = UTIL_W'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 2047)
                                                         : $urandom_range(0, 400));
    case ($urandom_range(0, 5))
      0:       r.capacity = UTIL_W'(1024);
      1:       r.capacity = UTIL_W'(512);
      2:       r.capacity = UTIL_W'(256);
      3:       r.capacity = UTIL_W'($urandom_range(0, 2047));
      default: r.capacity = UTIL_W'($urandom_range(0, 1024));
    endcase
    r.cluster_end  = ($urandom_range(0, 3) == 0);
    r.last_cpu     = ($urandom_range(0, 7) == 0);
    r.fallback_cpu = CPU_ID_W'($urandom_range(0, CPUS - 1));
    r.prefer_idle  = ($urandom_range(0, 4) != 0);
    return r;
  endfunction

  // Offer one request, hold it until taken, then maybe idle a while
  task automatic send_request(cpu_req_t r);
    int gap;
    s_tdata  <= {4'b0, r.prefer_idle, r.fallback_cpu, r.cluster_end, r.capacity, r.task_util,
                 r.cpu_load, r.is_idle, r.active, r.allowed, r.cpu_id};
    s_tlast  <= r.last_cpu;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_request(r);
    items_sent++;
    @(negedge clk);
    if (!tx_steady && $urandom_range(0, 9) < 4) begin
      gap = pick_gap();
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  // One placement: in-order CPUs with cluster ends, or a noisy run
  task automatic random_placement();
    int       n;
    bit       noise;
    cpu_req_t r;
    noise = ($urandom_range(0, 9) == 0);
    n     = noise ? $urandom_range(1, 6) : $urandom_range(1, CPUS);
    for (int k = 0; k < n; k++) begin
      r = random_req();
      if (!noise) begin
        r.cpu_id      = CPU_ID_W'(k);
        r.cluster_end = (k == n - 1) ? ($urandom_range(0, 3) != 0)
                                     : ($urandom_range(0, 3) == 0);
        r.last_cpu    = (k == n - 1);
      end else if (k == n - 1) begin
        r.last_cpu = 1'b1;
      end
      send_request(r);
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        stall_left     = 300;
        long_stall_req = 1'b0;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  initial begin
    #5ms;
    $display("idle_cpu_placement_selector_tb NOT OK");
    $finish;
  end

  initial begin
    int placements;
    int rand_start;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    rst      = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single idle CPU with zero load and zero capacity
    send_request(mk(3, 1, 1, 1, 0, 0, 0, 1, 1, 5, 1));
    // widest projection overflows capacity: falls back to previous CPU
    send_request(mk(0, 1, 1, 1, 2047, 2047, 2047, 1, 1, 7, 1));
    // prefer-idle off
    send_request(mk(2, 1, 1, 1, 10, 10, 100, 1, 1, 4, 0));
    // busy choice with held capacity, equal projection, ignore after decision
    send_request(mk(0, 1, 1, 0, 300, 300, 1024, 0, 0, 0, 1));
    send_request(mk(1, 1, 1, 0, 5, 5, 2047, 0, 0, 0, 1));
    send_request(mk(2, 1, 1, 0, 500, 12, 512, 0, 0, 0, 1));
    send_request(mk(3, 1, 1, 0, 500, 12, 512, 1, 0, 0, 1));
    send_request(mk(4, 1, 1, 1, 0, 0, 1024, 0, 0, 0, 1));
    send_request(mk(5, 1, 1, 1, 0, 0, 1024, 0, 1, 6, 1));
    // masked CPUs, empty first cluster, idle wins, last closes cluster
    send_request(mk(0, 0, 1, 1, 0, 0, 1024, 0, 0, 0, 1));
    send_request(mk(1, 1, 0, 1, 0, 0, 1024, 0, 0, 0, 1));
    send_request(mk(2, 1, 1, 0, 1024, 1, 1024, 1, 0, 0, 1));
    send_request(mk(3, 1, 1, 1, 60, 40, 1024, 0, 0, 0, 1));
    send_request(mk(4, 1, 1, 1, 25, 25, 1024, 0, 0, 0, 1));
    send_request(mk(5, 1, 1, 0, 5, 5, 1024, 0, 0, 0, 1));
    send_request(mk(6, 1, 1, 1, 100, 100, 1024, 0, 0, 0, 1));
    send_request(mk(7, 1, 1, 0, 1, 1, 1024, 0, 1, 2, 1));
    // decided placement, but prefer-idle off on the last CPU
    send_request(mk(1, 1, 1, 1, 0, 0, 1024, 1, 0, 0, 1));
    send_request(mk(2, 1, 1, 1, 0, 0, 1024, 0, 1, 3, 0));
    wait_all_results();

    // random placements in phases
    placements = 0;
    rand_start = items_sent;
    while (items_sent - rand_start < RAND_ITEMS) begin
      if (placements == 40) long_stall_req = 1'b1;
      if (placements == 100 || placements == 200) wait_all_results();
      tx_steady = (placements >= 120 && placements < 160);
      rx_steady = (placements >= 140 && placements < 180);
      random_placement();
      placements++;
    end

    // drain, then allow the result register to settle
    wait_all_results();
    repeat (10) @(negedge clk);
    if (sb.fail_count == 0 && sb.pending_q.size() == 0) begin
      $display("idle_cpu_placement_selector_tb OK");
    end else begin
      $display("idle_cpu_placement_selector_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/icps_pkg.sv
hdl/idle_cpu_placement_selector.sv
tb/idle_cpu_placement_selector_tb.sv
